>>> hdl/nns_pkg.sv
// Shared types, constants and helpers of the nearest-neighbor image scaler.
`timescale 1ns / 1ps
`default_nettype none

package nns_pkg;

	localparam int MAX_SOURCE_WIDTH_DEF = 2048;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [11:0] SOURCE_WIDTH_RST   = 12'd1;
	localparam logic [15:0] OUTPUT_WIDTH_RST   = 16'd1;
	localparam logic [15:0] OUTPUT_HEIGHT_RST  = 16'd1;
	localparam logic [23:0] INVERSE_FACTOR_RST = 24'd65536;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EMIT = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_PIXEL    = 2'd0,
		KIND_PAD      = 2'd1,
		KIND_NEED_ROW = 2'd2,
		KIND_DONE     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_SOURCE_WIDTH   = 2'd0,
		REG_OUTPUT_WIDTH   = 2'd1,
		REG_OUTPUT_HEIGHT  = 2'd2,
		REG_INVERSE_FACTOR = 2'd3
	} reg_index_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [10:0] column;
		logic [15:0] source_row;
		logic [7:0]  red_in;
		logic [7:0]  green_in;
		logic [7:0]  blue_in;
	} in_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [15:0] wanted_row;
		logic        row_end;
	} out_t;

	typedef struct packed {
		logic [11:0] source_width;
		logic [15:0] output_width;
		logic [15:0] output_height;
		logic [23:0] inverse_factor;
	} cfg_t;

	// One classified beat handed from the front to the back. The argument is the
	// buffer column for a load, the output column for a pixel and the wanted
	// source row for a row request.
	typedef struct packed {
		logic        load;
		kind_t       kind;
		logic        row_end;
		logic [15:0] arg;
		logic [23:0] rgb;
	} op_t;

	// Q24.16 product to a 16-bit index, saturating.
	function automatic logic [15:0] sat_index(input logic [39:0] prod);
		sat_index = (|prod[39:32]) ? 16'hFFFF : prod[31:16];
	endfunction

endpackage

`default_nettype wire

>>> hdl/nns_front.sv
// Front end: accepts input beats, tracks the output cursor and held row, classifies emits.
`timescale 1ns / 1ps
`default_nettype none

module nns_front import nns_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic item_valid,
	output logic      item_stall,
	input  wire in_t  item,
	input  wire cfg_t cfg,
	input  wire logic inv_wr,
	input  wire logic q_full,
	output logic      push,
	output op_t       push_op
);

	typedef enum logic [2:0] {
		SYNC_IDLE = 3'b001,
		SYNC_MUL  = 3'b010,
		SYNC_ADD  = 3'b100
	} sync_t;

	sync_t       sync_q, sync_d;
	logic [15:0] cx_q, cx_d;
	logic [15:0] cy_q, cy_d;
	logic [1:0]  pad_q, pad_d;
	logic        fin_q, fin_d;
	logic [15:0] hrow_q, hrow_d;
	logic        hval_q, hval_d;
	// acc_q is cursor_y times the factor; acc1_q is the same for the next row.
	logic [39:0] acc_q, acc_d;
	logic [39:0] acc1_q, acc1_d;

	logic        is_emit;
	logic        wrap_cond;
	logic        fix;
	logic        accept;
	logic        next_row;
	logic        done_now;
	logic [15:0] row;
	logic        row_miss;
	logic [15:0] cx_inc;
	logic [1:0]  pad_dec;
	logic [39:0] inv_ext;

	assign inv_ext   = 40'(cfg.inverse_factor);
	assign is_emit   = (item.opcode == OP_EMIT);
	// A cursor left past a shortened row moves to the next row before the emit.
	assign wrap_cond = !fin_q && (pad_q == 2'd0) && (cx_q >= cfg.output_width)
		&& (cfg.output_width != 16'd0);
	assign fix        = item_valid && is_emit && wrap_cond && (sync_q == SYNC_IDLE);
	assign item_stall = q_full || (sync_q != SYNC_IDLE) || (item_valid && is_emit && wrap_cond);
	assign accept     = item_valid && !item_stall;

	assign row      = sat_index(acc_q);
	assign row_miss = !hval_q || (hrow_q != row);
	assign done_now = fin_q || (cfg.output_width == 16'd0) || (cy_q >= cfg.output_height);
	assign cx_inc   = cx_q + 16'd1;
	assign pad_dec  = pad_q - 2'd1;

	always_comb begin
		sync_d   = sync_q;
		cx_d     = cx_q;
		cy_d     = cy_q;
		pad_d    = pad_q;
		fin_d    = fin_q;
		hrow_d   = hrow_q;
		hval_d   = hval_q;
		acc_d    = acc_q;
		acc1_d   = acc1_q;
		push     = 1'b0;
		push_op  = '0;
		next_row = fix;

		unique case (sync_q)
			SYNC_MUL: begin
				acc_d  = 40'(cy_q) * inv_ext;
				sync_d = SYNC_ADD;
			end
			SYNC_ADD: begin
				acc1_d = (cy_q == 16'hFFFF) ? 40'd0 : acc_q + inv_ext;
				sync_d = SYNC_IDLE;
			end
			SYNC_IDLE: begin
				sync_d = SYNC_IDLE;
			end
			default: begin
				sync_d = SYNC_IDLE;
			end
		endcase
		if (inv_wr) begin
			sync_d = SYNC_MUL;
		end

		if (accept) begin
			push = 1'b1;
			if (!is_emit) begin
				push_op.load = 1'b1;
				push_op.arg  = 16'(item.column);
				push_op.rgb  = {item.red_in, item.green_in, item.blue_in};
				hrow_d       = item.source_row;
				hval_d       = 1'b1;
			end else if (done_now) begin
				fin_d        = 1'b1;
				push_op.kind = KIND_DONE;
			end else if (pad_q != 2'd0) begin
				push_op.kind = KIND_PAD;
				if (pad_dec == 2'd0) begin
					push_op.row_end = 1'b1;
					next_row        = 1'b1;
				end else begin
					pad_d = pad_dec;
				end
			end else if (row_miss) begin
				push_op.kind = KIND_NEED_ROW;
				push_op.arg  = row;
			end else begin
				push_op.kind = KIND_PIXEL;
				push_op.arg  = cx_q;
				if ((cx_inc == cfg.output_width) || (cx_inc == 16'd0)) begin
					if (cfg.output_width[1:0] == 2'd0) begin
						push_op.row_end = 1'b1;
						next_row        = 1'b1;
					end else begin
						cx_d  = cfg.output_width;
						pad_d = cfg.output_width[1:0];
					end
				end else begin
					cx_d = cx_inc;
				end
			end
		end

		if (next_row) begin
			cx_d   = 16'd0;
			pad_d  = 2'd0;
			cy_d   = cy_q + 16'd1;
			acc_d  = acc1_q;
			acc1_d = (cy_d == 16'hFFFF) ? 40'd0 : acc1_q + inv_ext;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_IDLE;
			cx_q   <= '0;
			cy_q   <= '0;
			pad_q  <= '0;
			fin_q  <= 1'b0;
			hrow_q <= '0;
			hval_q <= 1'b0;
			acc_q  <= '0;
			acc1_q <= 40'(INVERSE_FACTOR_RST);
		end else begin
			sync_q <= sync_d;
			cx_q   <= cx_d;
			cy_q   <= cy_d;
			pad_q  <= pad_d;
			fin_q  <= fin_d;
			hrow_q <= hrow_d;
			hval_q <= hval_d;
			acc_q  <= acc_d;
			acc1_q <= acc1_d;
		end
	end

endmodule

`default_nettype wire

>>> hdl/nns_queue.sv
// Short queue of classified beats between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module nns_queue import nns_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	output logic      full,
	input  wire logic pop,
	output logic      pop_valid,
	output op_t       pop_op
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LastPtr = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(QUEUE_DEPTH);

	op_t           slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == FullCnt);
	assign pop_valid = (count_q != '0);
	assign pop_op    = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/nns_back.sv
// Back end: column scaling, line buffer and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none

module nns_back import nns_pkg::*; #(
	parameter int MAX_SOURCE_WIDTH = MAX_SOURCE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire op_t         q_op,
	output logic             q_pop,
	input  wire logic [11:0] source_width,
	input  wire logic [23:0] inverse_factor,
	output logic             result_valid,
	input  wire logic        result_stall,
	output out_t             result
);

	localparam int AW = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
	localparam logic [16:0] MaxW = 17'(MAX_SOURCE_WIDTH);

	logic [23:0]   line_mem [MAX_SOURCE_WIDTH];

	logic          adv;
	logic          s1_valid_q;
	op_t           s1_op;
	logic [39:0]   s1_prod;
	logic          s2_valid_q;
	op_t           s2_op;
	logic [23:0]   rd_s2;
	logic          res_valid_q;
	out_t          res_q;

	logic [16:0]   sw_ext;
	logic [16:0]   eff_w;
	logic [16:0]   col;
	logic [16:0]   col_clamped;
	logic [16:0]   wcol;
	logic [AW-1:0] raddr;
	logic [AW-1:0] waddr;
	logic          wr_ok;

	assign adv          = !res_valid_q || !result_stall;
	assign q_pop        = adv && q_valid;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Effective width is source_width held to 1 .. MAX_SOURCE_WIDTH.
	assign sw_ext      = 17'(source_width);
	assign eff_w       = (sw_ext == 17'd0) ? 17'd1 : ((sw_ext > MaxW) ? MaxW : sw_ext);
	assign col         = 17'(sat_index(s1_prod));
	assign col_clamped = (col >= eff_w) ? eff_w - 17'd1 : col;
	assign raddr       = col_clamped[AW-1:0];
	assign wcol        = 17'(s1_op.arg);
	assign wr_ok       = (wcol < MaxW);
	assign waddr       = wcol[AW-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_op   <= q_op;
			s1_prod <= 40'(q_op.arg) * 40'(inverse_factor);
			s2_op   <= s1_op;
			res_q.kind       <= s2_op.kind;
			res_q.row_end    <= s2_op.row_end;
			res_q.wanted_row <= (s2_op.kind == KIND_NEED_ROW) ? s2_op.arg : 16'd0;
			if (s2_op.kind == KIND_PIXEL) begin
				{res_q.red_out, res_q.green_out, res_q.blue_out} <= rd_s2;
			end else begin
				{res_q.red_out, res_q.green_out, res_q.blue_out} <= 24'd0;
			end
		end
	end

	// Loads and reads reach the buffer in queue order, one beat a cycle while not stalled.
	always_ff @(posedge clk) begin
		if (adv && s1_valid_q) begin
			if (s1_op.load) begin
				if (wr_ok) begin
					line_mem[waddr] <= s1_op.rgb;
				end
			end else begin
				rd_s2 <= line_mem[raddr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_q  <= q_valid;
			s2_valid_q  <= s1_valid_q;
			res_valid_q <= s2_valid_q && !s2_op.load;
		end
	end

endmodule

`default_nettype wire

>>> hdl/nearest_neighbor_image_scaler.sv
// Top level of the nearest-neighbor image scaler: configuration registers and wiring.
`timescale 1ns / 1ps
`default_nettype none

// The scaler takes one beat per clock while nothing stalls, load or emit alike,
// and returns one result for every emit; the front end, the four-entry queue and
// the three-stage back end (column multiply, line buffer read, result register)
// each pass one beat a cycle while nothing stalls. Writing inverse_factor holds
// off input while the front end recomputes the current row product with its
// multiplier. After output_width is lowered below the cursor, the next emit
// waits while the cursor moves to the following row.
module nearest_neighbor_image_scaler import nns_pkg::*; #(
	parameter int MAX_SOURCE_WIDTH = MAX_SOURCE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire in_t         item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output out_t             result,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	cfg_t cfg_q;
	logic inv_wr;
	logic push;
	op_t  push_op;
	logic q_full;
	logic q_pop;
	logic q_valid;
	op_t  q_op;

	assign inv_wr = cfg_we && (reg_index_t'(cfg_index) == REG_INVERSE_FACTOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_width   <= SOURCE_WIDTH_RST;
			cfg_q.output_width   <= OUTPUT_WIDTH_RST;
			cfg_q.output_height  <= OUTPUT_HEIGHT_RST;
			cfg_q.inverse_factor <= INVERSE_FACTOR_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SOURCE_WIDTH:   cfg_q.source_width   <= cfg_data[11:0];
				REG_OUTPUT_WIDTH:   cfg_q.output_width   <= cfg_data[15:0];
				REG_OUTPUT_HEIGHT:  cfg_q.output_height  <= cfg_data[15:0];
				REG_INVERSE_FACTOR: cfg_q.inverse_factor <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	nns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg        (cfg_q),
		.inv_wr     (inv_wr),
		.q_full     (q_full),
		.push       (push),
		.push_op    (push_op)
	);

	nns_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_op    (q_op)
	);

	nns_back #(
		.MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_op           (q_op),
		.q_pop          (q_pop),
		.source_width   (cfg_q.source_width),
		.inverse_factor (cfg_q.inverse_factor),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result)
	);

endmodule

`default_nettype wire

>>> hdl/nns_checker.sv
// Port-level checks on the scaler's result stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nns_port_checker import nns_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic result_valid,
	input wire logic result_stall,
	input wire out_t result
);

	logic done_seen_q;

	// Once the image is done, every later result reports done until reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q <= 1'b0;
		end else if (result_valid && !result_stall && (result.kind == KIND_DONE)) begin
			done_seen_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	a_color_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind != KIND_PIXEL) |->
			(result.red_out == 8'd0) && (result.green_out == 8'd0) && (result.blue_out == 8'd0))
		else $error("color bytes set on a beat that is not a pixel");

	a_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind != KIND_NEED_ROW) |-> (result.wanted_row == 16'd0))
		else $error("wanted row set on a beat that is not a row request");

	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.row_end |->
			(result.kind == KIND_PIXEL) || (result.kind == KIND_PAD))
		else $error("row end flagged on a request or done beat");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && done_seen_q |-> (result.kind == KIND_DONE))
		else $error("result other than done after the image finished");

endmodule

bind nearest_neighbor_image_scaler nns_port_checker u_nns_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
